### rtl/swr_pkg.sv
// ----------------------------------------------------------------------------
// swr_pkg
// Shared types and constants for the stream word replacer.
// ----------------------------------------------------------------------------
package swr_pkg;

   localparam int MAX_WORD_DEF = 8;   // default window depth
   localparam int REPL_MAX     = 8;   // replacement word capacity, chars
   localparam int COUNT_W      = 4;   // holds 0..REPL_MAX
   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int CSR_DATA_W   = 64;
   localparam int CSR_ADDR_W   = 5;

   typedef logic [7:0] char_type;

   typedef enum logic [1:0] {
      REG_SEARCH_WORD    = 2'd0,
      REG_SEARCH_LENGTH  = 2'd1,
      REG_REPLACE_WORD   = 2'd2,
      REG_REPLACE_LENGTH = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [63:0] search_word;
      logic [3:0]  search_length;
      logic [63:0] replace_word;
      logic [3:0]  replace_length;
   } cfg_type;

   // one item's worth of output work: emit chars[0..count-1], then mark end if eos
   typedef struct packed {
      char_type [REPL_MAX-1:0] chars;
      logic [COUNT_W-1:0]      count;
      logic                    eos;
   } desc_type;

endpackage

### rtl/swr_csr.sv
// ----------------------------------------------------------------------------
// swr_csr
// APB register file: search/replace words and their lengths.
// ----------------------------------------------------------------------------
module swr_csr
   import swr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type sel;
   logic          wr_en;

   assign pready = 1'b1;
   assign sel    = reg_index_type'(paddr[4:3]);
   assign wr_en  = psel && penable && pwrite;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (sel)
            REG_SEARCH_WORD:    cfg_in.search_word    = pwdata;
            REG_SEARCH_LENGTH:  cfg_in.search_length  = pwdata[3:0];
            REG_REPLACE_WORD:   cfg_in.replace_word   = pwdata;
            REG_REPLACE_LENGTH: cfg_in.replace_length = pwdata[3:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (sel)
         REG_SEARCH_WORD:    prdata = cfg_ff.search_word;
         REG_SEARCH_LENGTH:  prdata = {60'd0, cfg_ff.search_length};
         REG_REPLACE_WORD:   prdata = cfg_ff.replace_word;
         REG_REPLACE_LENGTH: prdata = {60'd0, cfg_ff.replace_length};
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.search_word    <= '0;
         cfg_ff.search_length  <= 4'd1;
         cfg_ff.replace_word   <= '0;
         cfg_ff.replace_length <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/swr_front.sv
// ----------------------------------------------------------------------------
// swr_front
// Keeps the character window, matches it against the search word and turns
// each accepted item into an output descriptor.
// ----------------------------------------------------------------------------
module swr_front
   import swr_pkg::*;
#(
   parameter int MAX_WORD = MAX_WORD_DEF
)
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  char_type in_char,
   input  logic     end_of_string,
   input  cfg_type  cfg,
   input  logic     q_full,
   output logic     q_push,
   output desc_type q_desc
);

   localparam int FILL_W = $clog2(MAX_WORD + 1);

   char_type [MAX_WORD-1:0] win_ff, win_in, win_after;
   logic [FILL_W-1:0]       fill_ff, fill_in;
   logic [FILL_W-1:0]       fill_after, slen, shift;
   logic [3:0]              slen4, rlen4;
   logic                    take, match;
   desc_type                desc;

   assign take = push && !q_full;

   always_comb begin
      slen4 = cfg.search_length;
      if (slen4 == 4'd0)
         slen4 = 4'd1;
      else if (slen4 > 4'(MAX_WORD))
         slen4 = 4'(MAX_WORD);
      slen  = FILL_W'(slen4);
      rlen4 = (cfg.replace_length > 4'(REPL_MAX)) ? 4'(REPL_MAX) : cfg.replace_length;

      fill_after = fill_ff + 1'b1;
      for (int i = 0; i < MAX_WORD; i++)
         win_after[i] = (FILL_W'(i) == fill_ff) ? in_char : win_ff[i];

      match = (fill_after == slen);
      for (int i = 0; i < MAX_WORD; i++)
         if (FILL_W'(i) < slen && win_after[i] != cfg.search_word[8*i +: 8])
            match = 1'b0;

      shift = fill_after - slen + 1'b1;

      desc.eos   = end_of_string;
      desc.count = '0;
      for (int j = 0; j < REPL_MAX; j++)
         desc.chars[j] = (j < MAX_WORD) ? win_after[j % MAX_WORD] : 8'd0;
      win_in  = win_after;
      fill_in = fill_after;

      if (match) begin
         desc.chars = cfg.replace_word;
         desc.count = rlen4;
         fill_in    = '0;
      end else if (end_of_string) begin
         desc.count = COUNT_W'(fill_after);
         fill_in    = '0;
      end else if (fill_after >= slen) begin
         desc.count = COUNT_W'(shift);
         fill_in    = slen - 1'b1;
         for (int i = 0; i < MAX_WORD; i++)
            for (int k = 1; k <= MAX_WORD; k++)
               if (FILL_W'(k) == shift && i + k < MAX_WORD)
                  win_in[i] = win_after[(i + k) % MAX_WORD];
      end
   end

   assign q_push = take && (desc.count != '0 || desc.eos);
   assign q_desc = desc;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (take) begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         win_ff <= win_in;
      end
   end

endmodule

### rtl/swr_queue.sv
// ----------------------------------------------------------------------------
// swr_queue
// Small descriptor FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module swr_queue
   import swr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     wr_en,
   input  desc_type wr_desc,
   input  logic     rd_en,
   output desc_type rd_desc,
   output logic     q_full,
   output logic     q_empty
);

   desc_type                 mem [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_PTR_W:0]     count_ff, count_in;
   logic                     do_wr, do_rd;

   assign q_full  = (count_ff == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
   assign q_empty = (count_ff == '0);
   assign do_wr   = wr_en && !q_full;
   assign do_rd   = rd_en && !q_empty;
   assign rd_desc = mem[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_wr && !do_rd)
         count_in = count_ff + 1'b1;
      else if (do_rd && !do_wr)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_wr)
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_rd)
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem[wr_ptr_ff] <= wr_desc;
      end
   end

endmodule

### rtl/swr_back.sv
// ----------------------------------------------------------------------------
// swr_back
// Serializes descriptors into output items, one per cycle while the consumer
// keeps popping, through an output register.
// ----------------------------------------------------------------------------
module swr_back
   import swr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  desc_type q_desc,
   input  logic     q_empty,
   output logic     q_pop,
   output logic     empty,
   input  logic     pop,
   output char_type out_char,
   output logic     char_valid,
   output logic     last_out
);

   desc_type   cur_ff;
   logic       cur_valid_ff, cur_valid_in;
   logic [2:0] idx_ff, idx_in, last_idx;
   logic       out_valid_ff, out_valid_in;
   char_type   out_char_ff;
   logic       char_valid_ff, last_out_ff;
   logic       slot_free, emit, desc_done, load;

   assign slot_free = !out_valid_ff || pop;
   assign emit      = slot_free && cur_valid_ff;
   assign last_idx  = (cur_ff.count == '0) ? 3'd0 : 3'(cur_ff.count - 1'b1);
   assign desc_done = emit && (idx_ff == last_idx);
   assign load      = (!cur_valid_ff || desc_done) && !q_empty;
   assign q_pop     = load;

   always_comb begin
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      if (emit)
         idx_in = idx_ff + 1'b1;
      if (desc_done)
         cur_valid_in = 1'b0;
      if (load) begin
         cur_valid_in = 1'b1;
         idx_in       = '0;
      end
      out_valid_in = out_valid_ff;
      if (pop)
         out_valid_in = 1'b0;
      if (emit)
         out_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load)
         cur_ff <= q_desc;
      if (emit) begin
         out_char_ff   <= (cur_ff.count == '0) ? 8'd0 : cur_ff.chars[idx_ff];
         char_valid_ff <= (cur_ff.count != '0);
         last_out_ff   <= cur_ff.eos && (idx_ff == last_idx);
      end
   end

   assign empty      = !out_valid_ff;
   assign out_char   = out_char_ff;
   assign char_valid = char_valid_ff;
   assign last_out   = last_out_ff;

endmodule

### rtl/stream_word_replacer.sv
// ----------------------------------------------------------------------------
// stream_word_replacer
// Replaces each leftmost, non-overlapping occurrence of a search word in a
// character stream with a replacement word.
// ----------------------------------------------------------------------------
// One character is taken per cycle while the descriptor queue has room. Each
// input item yields 0..8 output items (or one empty end item), and the output
// serializer sends one item per cycle while pop is held, so a replacement longer
// than one character, or a window flush at end of string, holds input off
// once the 4-entry queue fills. A result passes through the queue, the
// current-descriptor register and the output register. Configure only while
// the block is idle.
module stream_word_replacer
   import swr_pkg::*;
#(
   parameter int MAX_WORD = MAX_WORD_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic [7:0]            req_in_char,
   input  logic                  req_end_of_string,
   output logic                  empty,
   input  logic                  pop,
   output logic [7:0]            rsp_out_char,
   output logic                  rsp_char_valid,
   output logic                  rsp_last_out,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type  cfg;
   desc_type wr_desc, rd_desc;
   logic     q_wr, q_rd, q_full, q_empty;

   assign full = q_full;

   swr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   swr_front #(
      .MAX_WORD (MAX_WORD)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .in_char       (req_in_char),
      .end_of_string (req_end_of_string),
      .cfg           (cfg),
      .q_full        (q_full),
      .q_push        (q_wr),
      .q_desc        (wr_desc)
   );

   swr_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_wr),
      .wr_desc (wr_desc),
      .rd_en   (q_rd),
      .rd_desc (rd_desc),
      .q_full  (q_full),
      .q_empty (q_empty)
   );

   swr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_desc     (rd_desc),
      .q_empty    (q_empty),
      .q_pop      (q_rd),
      .empty      (empty),
      .pop        (pop),
      .out_char   (rsp_out_char),
      .char_valid (rsp_char_valid),
      .last_out   (rsp_last_out)
   );

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for stream_word_replacer. Strings are pushed one
// character per item while a local rewrite predictor, fed from the same
// register values, builds the expected output text. Every popped item is
// compared against it in order. Directed rows come first, then random strings
// built around the search word, under three patterns of idling on either side.
// ----------------------------------------------------------------------------
module tb
   import swr_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_WORD     = MAX_WORD_DEF;
   localparam int SETTLE       = 8;
   localparam int CYCLE_LIMIT  = 200000;

   typedef struct packed {
      char_type ch;
      logic     valid;
      logic     last;
   } out_char_type;

   typedef enum logic {ROW_CFG, ROW_CHAR} row_kind_type;

   typedef struct packed {
      row_kind_type  kind;
      reg_index_type idx;
      logic [63:0]   value;
      char_type      ch;
      logic          eos;
      logic          typed;
      out_char_type  want;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  push = 1'b0;
   logic                  full;
   logic [7:0]            req_in_char = '0;
   logic                  req_end_of_string = 1'b0;
   logic                  empty;
   logic                  pop = 1'b0;
   logic [7:0]            rsp_out_char;
   logic                  rsp_char_valid;
   logic                  rsp_last_out;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   cfg_type       cfg;
   char_type      held_chars [8];
   int            held_count;
   out_char_type  step_chars [$];
   out_char_type  rewritten_q [$];
   stim_row_type  stim_table [$];
   out_char_type  got_item;
   out_char_type  want_item;
   int            mismatch_count = 0;
   int            cycle_count = 0;
   int            send_idle = 13;
   int            recv_idle = 53;

   stream_word_replacer #(.MAX_WORD(MAX_WORD)) u_dut (
      .clock, .reset, .push, .full, .req_in_char, .req_end_of_string,
      .empty, .pop, .rsp_out_char, .rsp_char_valid, .rsp_last_out,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------- rewrite predictor ----------------

   function automatic int eff_search_len();
      if (cfg.search_length == 0) return 1;
      if (cfg.search_length > MAX_WORD) return MAX_WORD;
      return int'(cfg.search_length);
   endfunction

   function automatic char_type shift_out();
      char_type c;
      c = held_chars[0];
      for (int i = 1; i < 8; i++) held_chars[i-1] = held_chars[i];
      if (held_count > 0) held_count--;
      return c;
   endfunction

   function automatic void rewrite_char(input char_type ch, input logic eos);
      int           slen;
      int           rlen;
      bit           hit;
      out_char_type tail;
      step_chars.delete();
      slen = eff_search_len();
      rlen = (cfg.replace_length > 8) ? 8 : int'(cfg.replace_length);
      if (held_count < 8) begin
         held_chars[held_count] = ch;
         held_count++;
      end
      if (held_count > slen) begin
         while (held_count > (eos ? 0 : slen - 1))
            step_chars.push_back({shift_out(), 1'b1, 1'b0});
      end else begin
         if (held_count == slen) begin
            hit = 1'b1;
            for (int i = 0; i < slen; i++)
               if (held_chars[i] != cfg.search_word[8*i +: 8]) hit = 1'b0;
            if (hit) begin
               for (int i = 0; i < rlen; i++)
                  step_chars.push_back({cfg.replace_word[8*i +: 8], 1'b1, 1'b0});
               held_count = 0;
            end else begin
               step_chars.push_back({shift_out(), 1'b1, 1'b0});
            end
         end
         if (eos)
            while (held_count > 0) step_chars.push_back({shift_out(), 1'b1, 1'b0});
      end
      if (eos) begin
         if (step_chars.size() == 0) step_chars.push_back({8'h00, 1'b0, 1'b0});
         tail = step_chars.pop_back();
         tail.last = 1'b1;
         step_chars.push_back(tail);
         held_count = 0;
      end
   endfunction

   // ---------------- drivers ----------------

   task automatic send_item(input char_type ch, input logic eos,
                            input logic typed = 1'b0, input out_char_type want = '0);
      while ($urandom_range(99) < send_idle) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_in_char <= ch;
      req_end_of_string <= eos;
      do @(posedge clock); while (full);
      rewrite_char(ch, eos);
      if (typed) rewritten_q.push_back(want);
      else foreach (step_chars[i]) rewritten_q.push_back(step_chars[i]);
   endtask

   task automatic drain_out();
      push <= 1'b0;
      while (rewritten_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [63:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 3'b000};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_SEARCH_WORD:    cfg.search_word = value;
         REG_SEARCH_LENGTH:  cfg.search_length = value[3:0];
         REG_REPLACE_WORD:   cfg.replace_word = value;
         REG_REPLACE_LENGTH: cfg.replace_length = value[3:0];
         default:            cfg = cfg;
      endcase
   endtask

   function automatic logic [3:0] pick_search_len();
      case ($urandom_range(9))
         0:       return 4'd0;
         1:       return 4'($urandom_range(9, 15));
         2:       return 4'd8;
         default: return 4'($urandom_range(1, 4));
      endcase
   endfunction

   task automatic reconfigure();
      logic [3:0] rlen;
      case ($urandom_range(7))
         0:       rlen = 4'd0;
         1:       rlen = 4'($urandom_range(9, 15));
         2:       rlen = 4'd8;
         default: rlen = 4'($urandom_range(1, 3));
      endcase
      csr_write(REG_SEARCH_WORD, {$urandom, $urandom});
      csr_write(REG_SEARCH_LENGTH, 64'(pick_search_len()));
      csr_write(REG_REPLACE_WORD, {$urandom, $urandom});
      csr_write(REG_REPLACE_LENGTH, 64'(rlen));
   endtask

   // strings made mostly of search-word bytes and whole search words
   task automatic run_random(input int n_items);
      char_type text [$];
      int       sent;
      int       len;
      int       slen;
      int       split;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(3) == 0) begin
            drain_out();
            reconfigure();
         end
         text.delete();
         slen = eff_search_len();
         len = $urandom_range(1, 12);
         while (text.size() < len) begin
            if ($urandom_range(2) == 0) begin
               for (int i = 0; i < slen; i++) text.push_back(cfg.search_word[8*i +: 8]);
            end else if ($urandom_range(9) == 0) begin
               text.push_back(char_type'($urandom_range(255)));
            end else begin
               text.push_back(cfg.search_word[8*$urandom_range(slen - 1) +: 8]);
            end
         end
         split = ($urandom_range(11) == 0) ? text.size() / 2 : -1;
         foreach (text[i]) begin
            if (i == split && i > 0) begin
               drain_out();
               csr_write(REG_SEARCH_LENGTH, 64'(pick_search_len()));
            end
            send_item(text[i], i == text.size() - 1);
            sent++;
         end
      end
   endtask

   // ---------------- output checker ----------------

   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            got_item = {rsp_out_char, rsp_char_valid, rsp_last_out};
            if (rewritten_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected item: char %h valid %b last %b",
                           got_item.ch, got_item.valid, got_item.last);
            end else begin
               want_item = rewritten_q.pop_front();
               if (got_item.ch !== want_item.ch || got_item.valid !== want_item.valid ||
                   got_item.last !== want_item.last) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"mismatch: expected char %h valid %b last %b,",
                               " got char %h valid %b last %b"},
                              want_item.ch, want_item.valid, want_item.last,
                              got_item.ch, got_item.valid, got_item.last);
               end
            end
         end
         pop <= ($urandom_range(99) >= recv_idle);
      end
   end

   // ---------------- directed table ----------------

   function automatic void add_cfg(input reg_index_type idx, input logic [63:0] value);
      stim_row_type r;
      r = '0;
      r.kind = ROW_CFG;
      r.idx = idx;
      r.value = value;
      stim_table.push_back(r);
   endfunction

   function automatic void add_char(input char_type ch, input logic eos,
                                    input logic typed = 1'b0,
                                    input out_char_type want = '0);
      stim_row_type r;
      r = '0;
      r.kind = ROW_CHAR;
      r.ch = ch;
      r.eos = eos;
      r.typed = typed;
      r.want = want;
      stim_table.push_back(r);
   endfunction

   initial begin
      cfg = '0;
      cfg.search_length = 4'd1;
      held_count = 0;

      // reset state: nul search word of one char, empty replacement
      add_char(8'h00, 1'b1, 1'b1, {8'h00, 1'b0, 1'b1});
      add_char(8'hFF, 1'b1, 1'b1, {8'hFF, 1'b1, 1'b1});

      add_cfg(REG_SEARCH_WORD, 64'h0000_0000_0074_6163);
      add_cfg(REG_SEARCH_LENGTH, 64'd3);
      add_cfg(REG_REPLACE_WORD, 64'h0000_0000_2167_6f64);
      add_cfg(REG_REPLACE_LENGTH, 64'd4);
      add_char("x", 1'b0);
      add_char("c", 1'b0);
      add_char("c", 1'b0);
      add_char("a", 1'b0);
      add_char("t", 1'b0);
      add_char("a", 1'b1);

      // zero search length acts as one, oversize replace length saturates
      add_cfg(REG_SEARCH_WORD, 64'h41);
      add_cfg(REG_SEARCH_LENGTH, 64'd0);
      add_cfg(REG_REPLACE_WORD, 64'hFFFF_FFFF_FFFF_FFFF);
      add_cfg(REG_REPLACE_LENGTH, 64'd15);
      add_char("A", 1'b0);
      add_char("B", 1'b1, 1'b1, {8'h42, 1'b1, 1'b1});

      // oversize search length saturates to full window
      add_cfg(REG_SEARCH_WORD, 64'h8786_8584_8382_8180);
      add_cfg(REG_SEARCH_LENGTH, 64'd15);
      add_cfg(REG_REPLACE_LENGTH, 64'd0);
      for (int i = 0; i < 8; i++) add_char(char_type'(8'h80 + i), 1'b0);
      add_char("Z", 1'b1, 1'b1, {8'h5A, 1'b1, 1'b1});

      // search length lowered with characters still held
      add_char(8'h01, 1'b0);
      add_char(8'h02, 1'b0);
      add_char(8'h03, 1'b0);
      add_cfg(REG_SEARCH_LENGTH, 64'd2);
      add_char(8'h04, 1'b0);
      add_char(8'h05, 1'b1);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stim_table[i]) begin
         if (stim_table[i].kind == ROW_CFG) begin
            drain_out();
            csr_write(stim_table[i].idx, stim_table[i].value);
         end else begin
            send_item(stim_table[i].ch, stim_table[i].eos, stim_table[i].typed,
                      stim_table[i].want);
         end
      end

      run_random(69);
      send_idle = 53;
      recv_idle = 13;
      run_random(69);
      send_idle = 0;
      recv_idle = 0;
      run_random(68);
      drain_out();
      repeat (SETTLE) @(posedge clock);

      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

### filelist.f
rtl/swr_pkg.sv
rtl/swr_csr.sv
rtl/swr_front.sv
rtl/swr_queue.sv
rtl/swr_back.sv
rtl/stream_word_replacer.sv
bench/tb.sv
